[hdl/pcxrle_pkg.sv]
// Shared types and constants for the PCX run-length plane decoder.
package pcxrle_pkg;

	localparam int MAX_PLANES = 4;

	localparam logic [7:0] RUN_MARK = 8'hc0;
	localparam int CNT_W = 6;
	localparam int CMD_DEPTH = 4;
	localparam int CMD_AW = 2;
	localparam int CMD_CW = 3;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_LINE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 2'd1;

	localparam logic [15:0] BPL_RESET = 16'd320;
	localparam logic [2:0] PLANE_COUNT_RESET = 3'd3;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       frame_start;
	} code_item_t;

	typedef struct packed {
		logic [7:0]  pixel_byte;
		logic [1:0]  plane_index;
		logic [15:0] column_index;
		logic        line_end;
		logic        last_of_run;
	} pixel_item_t;

	typedef struct packed {
		logic [7:0]       value;
		logic [CNT_W-1:0] count;
		logic             clear;
	} cmd_t;

endpackage

[hdl/pcx_rle_plane_decoder_core.sv]
// Top level of the PCX run-length plane decoder: config registers and datapath wiring.
// A code byte is taken by the front end whenever the four-entry command queue has
// room; a run marker only arms the front end, but on a frame start also queues a clear
// command. The back-end emitter makes one result per cycle while the output register
// is free or popped: a command is loaded, then its bytes are emitted, and none loads
// until its run ends, so a run stalls input once the queue fills. Results wait until
// popped. Configuration writes are always ready and take effect the next cycle.
module pcx_rle_plane_decoder_core #(
	parameter int MAX_PLANES = pcxrle_pkg::MAX_PLANES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  pcxrle_pkg::code_item_t              item,
	output logic                                empty,
	input  logic                                pop,
	output pcxrle_pkg::pixel_item_t             result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pcxrle_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [15:0]                         cfg_data
);

	logic [15:0]      bytes_per_line_q;
	logic [2:0]       plane_count_q;
	logic             accept;
	logic             cmd_push;
	pcxrle_pkg::cmd_t cmd_in;
	pcxrle_pkg::cmd_t cmd_out;
	logic             cmd_avail;
	logic             cmd_take;
	logic             out_valid;

	assign cfg_ready = 1'b1;
	assign accept    = push & ~full;
	assign empty     = ~out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_per_line_q <= pcxrle_pkg::BPL_RESET;
			plane_count_q    <= pcxrle_pkg::PLANE_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pcxrle_pkg::REG_BYTES_PER_LINE: bytes_per_line_q <= cfg_data;
				pcxrle_pkg::REG_PLANE_COUNT:    plane_count_q    <= cfg_data[2:0];
				default:                        ;
			endcase
		end
	end

	pcxrle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	pcxrle_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_push),
		.wr_data (cmd_in),
		.full    (full),
		.rd      (cmd_take),
		.avail   (cmd_avail),
		.rd_data (cmd_out)
	);

	pcxrle_back #(
		.MAX_PLANES (MAX_PLANES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.bytes_per_line (bytes_per_line_q),
		.plane_count    (plane_count_q),
		.cmd_avail      (cmd_avail),
		.cmd            (cmd_out),
		.cmd_take       (cmd_take),
		.out_valid      (out_valid),
		.out_take       (pop),
		.out_item       (result)
	);

endmodule

[hdl/pcxrle_front.sv]
// Front end: accepts code bytes, tracks run markers and issues emit commands.
module pcxrle_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  pcxrle_pkg::code_item_t item,
	output logic                 cmd_push,
	output pcxrle_pkg::cmd_t     cmd
);

	logic                          marker_pending_q;
	logic [pcxrle_pkg::CNT_W-1:0]  pending_count_q;
	logic                          pend;
	logic                          is_mark;

	assign pend    = marker_pending_q & ~item.frame_start;
	assign is_mark = (item.code_byte & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK;

	always_comb begin
		cmd.value = item.code_byte;
		cmd.clear = item.frame_start;
		cmd.count = '0;
		cmd_push  = 1'b0;
		if (pend) begin
			cmd.count = pending_count_q;
			cmd_push  = accept & (pending_count_q != '0);
		end else if (is_mark) begin
			cmd_push = accept & item.frame_start;
		end else begin
			cmd.count = pcxrle_pkg::CNT_W'(1);
			cmd_push  = accept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_pending_q <= 1'b0;
			pending_count_q  <= '0;
		end else if (accept) begin
			if (!pend && is_mark) begin
				marker_pending_q <= 1'b1;
				pending_count_q  <= item.code_byte[pcxrle_pkg::CNT_W-1:0];
			end else begin
				marker_pending_q <= 1'b0;
				pending_count_q  <= '0;
			end
		end
	end

endmodule

[hdl/pcxrle_fifo.sv]
// Short command queue between the front end and the emitter.
module pcxrle_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  pcxrle_pkg::cmd_t wr_data,
	output logic             full,
	input  logic             rd,
	output logic             avail,
	output pcxrle_pkg::cmd_t rd_data
);

	pcxrle_pkg::cmd_t                mem [pcxrle_pkg::CMD_DEPTH];
	logic [pcxrle_pkg::CMD_AW-1:0]   wr_ptr_q;
	logic [pcxrle_pkg::CMD_AW-1:0]   rd_ptr_q;
	logic [pcxrle_pkg::CMD_CW-1:0]   count_q;

	assign full    = count_q == pcxrle_pkg::CMD_CW'(pcxrle_pkg::CMD_DEPTH);
	assign avail   = count_q != '0;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !wr)
		else $error("command queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!avail |-> !rd)
		else $error("command queue underflow");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> count_q == $past(count_q) + 1'b1)
		else $error("command queue count did not advance");

endmodule

[hdl/pcxrle_back.sv]
// Back end: replays commands as tagged plane bytes into the result register.
module pcxrle_back #(
	parameter int MAX_PLANES = pcxrle_pkg::MAX_PLANES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [15:0]             bytes_per_line,
	input  logic [2:0]              plane_count,
	input  logic                    cmd_avail,
	input  pcxrle_pkg::cmd_t        cmd,
	output logic                    cmd_take,
	output logic                    out_valid,
	input  logic                    out_take,
	output pcxrle_pkg::pixel_item_t out_item
);

	localparam logic [2:0] PL_MAX = 3'(MAX_PLANES);

	logic [pcxrle_pkg::CNT_W-1:0] remain_q;
	logic [7:0]                   value_q;
	logic [15:0]                  column_q;
	logic [1:0]                   plane_q;
	logic                         out_valid_q;
	pcxrle_pkg::pixel_item_t      out_q;

	logic [15:0] col_last;
	logic [2:0]  pl_lim;
	logic [1:0]  pl_last;
	logic        col_end;
	logic        pl_end;
	logic        advance;
	logic        emit;

	assign col_last = bytes_per_line - 16'd1;
	always_comb begin
		if (plane_count == 3'd0) begin
			pl_lim = 3'd1;
		end else if (plane_count > PL_MAX) begin
			pl_lim = PL_MAX;
		end else begin
			pl_lim = plane_count;
		end
	end
	assign pl_last = 2'(pl_lim - 3'd1);

	assign col_end  = column_q >= col_last;
	assign pl_end   = plane_q >= pl_last;
	assign advance  = !out_valid_q || out_take;
	assign emit     = (remain_q != '0) && advance;
	assign cmd_take = (remain_q == '0) && cmd_avail;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			value_q <= cmd.value;
		end
		if (emit) begin
			out_q.pixel_byte   <= value_q;
			out_q.plane_index  <= plane_q;
			out_q.column_index <= column_q;
			out_q.line_end     <= col_end & pl_end;
			out_q.last_of_run  <= remain_q == pcxrle_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q    <= '0;
			column_q    <= '0;
			plane_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= emit;
			end
			if (cmd_take) begin
				remain_q <= cmd.count;
				if (cmd.clear) begin
					column_q <= '0;
					plane_q  <= '0;
				end
			end else if (emit) begin
				remain_q <= remain_q - 1'b1;
				if (col_end) begin
					column_q <= '0;
					plane_q  <= pl_end ? 2'd0 : plane_q + 2'd1;
				end else begin
					column_q <= column_q + 16'd1;
				end
			end
		end
	end

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(remain_q != '0) |-> !cmd_take)
		else $error("command loaded while a run is in progress");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && remain_q == pcxrle_pkg::CNT_W'(1)) |=> remain_q == '0)
		else $error("run did not end after its last byte");
	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_take) |=> out_valid_q && $stable(out_q))
		else $error("waiting result changed before it was taken");

endmodule
